// ----- hdl/isb_pkg.sv -----
// Shared types and constants for the bilinear image scaler.
// No dependencies; imported by every module of the block except isb_ram.
package isb_pkg;

    // Fixed field widths of the item and configuration ports
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 8;
    localparam int SCALE_W    = 20;
    localparam int SIZE_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int PROD_W     = COORD_W + SCALE_W;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST    = 20'd65536;
    localparam int                 SRC_SIZE_RST = 256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd2;

    // Item opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Pipeline depth, input beat to result register
    localparam int PIPE_STAGES = 5;

    // Per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

endpackage

// ----- hdl/image_scale_bilinear_unit.sv -----
// Bilinear image scaler, top level: handshake control, config registers, stages.
// Results: a sample's result is registered in stage 5; loads give none.
// Throughput: one beat per cycle, loads and samples mixed, unless out_ready stalls the
// result; the four frame store banks give the four neighbors, one read port each, at once.
// Reset: clears stage valids and restores the config defaults; the frame store is
// not cleared and reads garbage until written.
module image_scale_bilinear_unit #(
    parameter int MAX_WIDTH  = isb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = isb_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = isb_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic [isb_pkg::COORD_W-1:0]      coord_x,
    input  logic [isb_pkg::COORD_W-1:0]      coord_y,
    input  logic [isb_pkg::PIX_W-1:0]        pixel_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [isb_pkg::PIX_W-1:0]        pixel_out,
    output logic                             clamped,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [isb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [isb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import isb_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int LX_W  = (SIZE_W > COL_W + 1) ? SIZE_W : COL_W + 1;
    localparam int LY_W  = (SIZE_W > ROW_W + 1) ? SIZE_W : ROW_W + 1;
    localparam logic [COL_W-1:0] WLAST_RST =
        COL_W'(((SRC_SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : SRC_SIZE_RST) - 1);
    localparam logic [ROW_W-1:0] HLAST_RST =
        ROW_W'(((SRC_SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : SRC_SIZE_RST) - 1);

    // Config registers; sizes kept as last index after limiting
    logic [SCALE_W-1:0] scale_reg;
    logic [COL_W-1:0]   wlast_reg;
    logic [ROW_W-1:0]   hlast_reg;
    logic [COL_W-1:0]   wlast_next;
    logic [ROW_W-1:0]   hlast_next;
    logic [LX_W-1:0]    wv;
    logic [LY_W-1:0]    hv;

    assign cfg_ready = 1'b1;

    // zero counts as one, oversize saturates to the store
    always_comb
    begin
        wv = LX_W'(cfg_data[SIZE_W-1:0]);
        hv = LY_W'(cfg_data[SIZE_W-1:0]);
        if (wv == '0)
        begin
            wlast_next = '0;
        end
        else if (wv > LX_W'(MAX_WIDTH))
        begin
            wlast_next = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast_next = COL_W'(wv - LX_W'(1));
        end
        if (hv == '0)
        begin
            hlast_next = '0;
        end
        else if (hv > LY_W'(MAX_HEIGHT))
        begin
            hlast_next = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            hlast_next = ROW_W'(hv - LY_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RST;
            wlast_reg <= WLAST_RST;
            hlast_reg <= HLAST_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INV_SCALE:  scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_SRC_WIDTH:  wlast_reg <= wlast_next;
                CFG_SRC_HEIGHT: hlast_reg <= hlast_next;
                default:        ;
            endcase
        end
    end

    // Stage valids and ready chain; a stage loads when it is empty or drains
    logic     v1_reg;
    logic     v2_reg;
    logic     v3_reg;
    logic     v4_reg;
    logic     v5_reg;
    pipe_en_t en;
    logic     samp2;

    assign en.s5 = !v5_reg || out_ready;
    assign en.s4 = !v4_reg || en.s5;
    assign en.s3 = !v3_reg || en.s4;
    assign en.s2 = !v2_reg || en.s3;
    assign en.s1 = !v1_reg || en.s2;

    assign in_ready  = en.s1;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= in_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            // loads retire after their write in stage 2
            if (en.s3)
            begin
                v3_reg <= v2_reg && samp2;
            end
            if (en.s4)
            begin
                v4_reg <= v3_reg;
            end
            if (en.s5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Datapath
    logic                 wr2;
    logic [COL_W-1:0]     x0;
    logic [ROW_W-1:0]     y0;
    logic                 xs;
    logic                 ys;
    logic [FRAC_BITS-1:0] fx2;
    logic [FRAC_BITS-1:0] fy2;
    logic                 sat2;
    logic [PIX_W-1:0]     pix2;
    logic [PIX_W-1:0]     p00;
    logic [PIX_W-1:0]     p10;
    logic [PIX_W-1:0]     p01;
    logic [PIX_W-1:0]     p11;
    logic [FRAC_BITS-1:0] fx3;
    logic [FRAC_BITS-1:0] fy3;
    logic                 sat3;

    isb_map #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_map (
        .clk           (clk),
        .en            (en),
        .opcode        (opcode),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .pixel_in      (pixel_in),
        .inverse_scale (scale_reg),
        .wlast         (wlast_reg),
        .hlast         (hlast_reg),
        .is_sample     (samp2),
        .wr_en         (wr2),
        .x0            (x0),
        .y0            (y0),
        .x_step        (xs),
        .y_step        (ys),
        .frac_x        (fx2),
        .frac_y        (fy2),
        .sat           (sat2),
        .pix           (pix2)
    );

    isb_fetch #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_fetch (
        .clk     (clk),
        .en      (en),
        .valid2  (v2_reg),
        .wr_en   (wr2),
        .x0      (x0),
        .y0      (y0),
        .x_step  (xs),
        .y_step  (ys),
        .frac_x  (fx2),
        .frac_y  (fy2),
        .sat     (sat2),
        .pix     (pix2),
        .p00     (p00),
        .p10     (p10),
        .p01     (p01),
        .p11     (p11),
        .frac_x3 (fx3),
        .frac_y3 (fy3),
        .sat3    (sat3)
    );

    isb_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk       (clk),
        .en        (en),
        .p00       (p00),
        .p10       (p10),
        .p01       (p01),
        .p11       (p11),
        .frac_x    (fx3),
        .frac_y    (fy3),
        .sat       (sat3),
        .pixel_out (pixel_out),
        .clamped   (clamped)
    );

endmodule

// ----- hdl/isb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module isb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/isb_map.sv -----
// Coordinate mapping stages: scale multiply, base/fraction split, edge saturation.
// Depends on isb_pkg.
module isb_map #(
    parameter int MAX_WIDTH  = isb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = isb_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = isb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  isb_pkg::pipe_en_t                 en,
    input  logic                              opcode,
    input  logic [isb_pkg::COORD_W-1:0]       coord_x,
    input  logic [isb_pkg::COORD_W-1:0]       coord_y,
    input  logic [isb_pkg::PIX_W-1:0]         pixel_in,
    input  logic [isb_pkg::SCALE_W-1:0]       inverse_scale,
    input  logic [$clog2(MAX_WIDTH)-1:0]      wlast,
    input  logic [$clog2(MAX_HEIGHT)-1:0]     hlast,
    output logic                              is_sample,
    output logic                              wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]      x0,
    output logic [$clog2(MAX_HEIGHT)-1:0]     y0,
    output logic                              x_step,
    output logic                              y_step,
    output logic [FRAC_BITS-1:0]              frac_x,
    output logic [FRAC_BITS-1:0]              frac_y,
    output logic                              sat,
    output logic [isb_pkg::PIX_W-1:0]         pix
);
    import isb_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int BASE_W = PROD_W - FRAC_BITS;
    localparam int CX_W   = (BASE_W > COL_W) ? BASE_W : COL_W;
    localparam int CY_W   = (BASE_W > ROW_W) ? BASE_W : ROW_W;
    localparam int LD_W   = COORD_W + 1;

    // Stage 1: products and raw load fields
    logic                op1_reg;
    logic [COORD_W-1:0]  cx1_reg;
    logic [COORD_W-1:0]  cy1_reg;
    logic [PIX_W-1:0]    pix1_reg;
    logic [PROD_W-1:0]   prodx1_reg;
    logic [PROD_W-1:0]   prody1_reg;
    logic [PROD_W-1:0]   prodx_next;
    logic [PROD_W-1:0]   prody_next;

    assign prodx_next = PROD_W'(coord_x) * PROD_W'(inverse_scale);
    assign prody_next = PROD_W'(coord_y) * PROD_W'(inverse_scale);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            op1_reg    <= opcode;
            cx1_reg    <= coord_x;
            cy1_reg    <= coord_y;
            pix1_reg   <= pixel_in;
            prodx1_reg <= prodx_next;
            prody1_reg <= prody_next;
        end
    end

    // Split into base and fraction, saturate base to last column/row
    logic [BASE_W-1:0]    bx;
    logic [BASE_W-1:0]    by;
    logic                 satx;
    logic                 saty;
    logic [COL_W-1:0]     x0_next;
    logic [ROW_W-1:0]     y0_next;
    logic                 xs_next;
    logic                 ys_next;
    logic                 inx;
    logic                 iny;
    logic                 wr_next;

    always_comb
    begin
        bx   = prodx1_reg[PROD_W-1:FRAC_BITS];
        by   = prody1_reg[PROD_W-1:FRAC_BITS];
        satx = CX_W'(bx) > CX_W'(wlast);
        saty = CY_W'(by) > CY_W'(hlast);
        // loads keep their own coordinate
        if (op1_reg == OP_SAMPLE)
        begin
            x0_next = satx ? wlast : COL_W'(bx);
            y0_next = saty ? hlast : ROW_W'(by);
        end
        else
        begin
            x0_next = COL_W'(cx1_reg);
            y0_next = ROW_W'(cy1_reg);
        end
        xs_next = x0_next < wlast;
        ys_next = y0_next < hlast;
        inx     = {1'b0, cx1_reg} < LD_W'(MAX_WIDTH);
        iny     = {1'b0, cy1_reg} < LD_W'(MAX_HEIGHT);
        wr_next = (op1_reg == OP_LOAD) && inx && iny;
    end

    // Stage 2 registers
    logic                 samp2_reg;
    logic                 wr2_reg;
    logic [COL_W-1:0]     x02_reg;
    logic [ROW_W-1:0]     y02_reg;
    logic                 xs2_reg;
    logic                 ys2_reg;
    logic [FRAC_BITS-1:0] fx2_reg;
    logic [FRAC_BITS-1:0] fy2_reg;
    logic                 sat2_reg;
    logic [PIX_W-1:0]     pix2_reg;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            samp2_reg <= (op1_reg == OP_SAMPLE);
            wr2_reg   <= wr_next;
            x02_reg   <= x0_next;
            y02_reg   <= y0_next;
            xs2_reg   <= xs_next;
            ys2_reg   <= ys_next;
            fx2_reg   <= prodx1_reg[FRAC_BITS-1:0];
            fy2_reg   <= prody1_reg[FRAC_BITS-1:0];
            sat2_reg  <= satx || saty;
            pix2_reg  <= pix1_reg;
        end
    end

    assign is_sample = samp2_reg;
    assign wr_en     = wr2_reg;
    assign x0        = x02_reg;
    assign y0        = y02_reg;
    assign x_step    = xs2_reg;
    assign y_step    = ys2_reg;
    assign frac_x    = fx2_reg;
    assign frac_y    = fy2_reg;
    assign sat       = sat2_reg;
    assign pix       = pix2_reg;

endmodule

// ----- hdl/isb_fetch.sv -----
// Frame store in four banks split by column and row parity, so the four
// neighbors of a sample come out in one read. Depends on isb_pkg, isb_ram.
module isb_fetch #(
    parameter int MAX_WIDTH  = isb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = isb_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = isb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  isb_pkg::pipe_en_t                 en,
    input  logic                              valid2,
    input  logic                              wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]      x0,
    input  logic [$clog2(MAX_HEIGHT)-1:0]     y0,
    input  logic                              x_step,
    input  logic                              y_step,
    input  logic [FRAC_BITS-1:0]              frac_x,
    input  logic [FRAC_BITS-1:0]              frac_y,
    input  logic                              sat,
    input  logic [isb_pkg::PIX_W-1:0]         pix,
    output logic [isb_pkg::PIX_W-1:0]         p00,
    output logic [isb_pkg::PIX_W-1:0]         p10,
    output logic [isb_pkg::PIX_W-1:0]         p01,
    output logic [isb_pkg::PIX_W-1:0]         p11,
    output logic [FRAC_BITS-1:0]              frac_x3,
    output logic [FRAC_BITS-1:0]              frac_y3,
    output logic                              sat3
);
    import isb_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int HALF_W = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BA_W   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int FA_W   = COL_W + ROW_W + 1;

    logic                 wr_go;
    logic [PIX_W-1:0]     rd_data [4];

    // a load writes when it leaves stage 2
    assign wr_go = en.s3 && valid2 && wr_en;

    // Bank b holds pixels with column parity b[0] and row parity b[1]
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam int PX = b % 2;
        localparam int PY = b / 2;

        logic [COL_W-1:0] hc;
        logic [ROW_W-1:0] hr;
        logic [FA_W-1:0]  addr_full;
        logic [BA_W-1:0]  addr;
        logic             we;

        // column/row in this bank: base itself, or base plus one
        always_comb
        begin
            if (PX == 0)
            begin
                hc = COL_W'(x0 >> 1) + COL_W'(x0[0]);
            end
            else
            begin
                hc = COL_W'(x0 >> 1);
            end
            if (PY == 0)
            begin
                hr = ROW_W'(y0 >> 1) + ROW_W'(y0[0]);
            end
            else
            begin
                hr = ROW_W'(y0 >> 1);
            end
            addr_full = FA_W'(hr) * FA_W'(HALF_W) + FA_W'(hc);
            addr      = BA_W'(addr_full);
            we        = wr_go && (x0[0] == 1'(PX)) && (y0[0] == 1'(PY));
        end

        isb_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (addr),
            .wdata (pix),
            .re    (en.s3),
            .raddr (addr),
            .rdata (rd_data[b])
        );
    end

    // Stage 3 side registers, aligned with the RAM read data
    logic                 xpar3_reg;
    logic                 ypar3_reg;
    logic                 xs3_reg;
    logic                 ys3_reg;
    logic [FRAC_BITS-1:0] fx3_reg;
    logic [FRAC_BITS-1:0] fy3_reg;
    logic                 sat3_reg;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            xpar3_reg <= x0[0];
            ypar3_reg <= y0[0];
            xs3_reg   <= x_step;
            ys3_reg   <= y_step;
            fx3_reg   <= frac_x;
            fy3_reg   <= frac_y;
            sat3_reg  <= sat;
        end
    end

    // Route bank outputs to neighbor positions; at an edge reuse the base
    logic x1par;
    logic y1par;

    always_comb
    begin
        x1par = xs3_reg ? ~xpar3_reg : xpar3_reg;
        y1par = ys3_reg ? ~ypar3_reg : ypar3_reg;
        p00   = rd_data[{ypar3_reg, xpar3_reg}];
        p10   = rd_data[{ypar3_reg, x1par}];
        p01   = rd_data[{y1par, xpar3_reg}];
        p11   = rd_data[{y1par, x1par}];
    end

    assign frac_x3 = fx3_reg;
    assign frac_y3 = fy3_reg;
    assign sat3    = sat3_reg;

endmodule

// ----- hdl/isb_blend.sv -----
// Blend stages: horizontal interpolation of both rows, then vertical, truncated.
// Depends on isb_pkg.
module isb_blend #(
    parameter int FRAC_BITS = isb_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  isb_pkg::pipe_en_t           en,
    input  logic [isb_pkg::PIX_W-1:0]   p00,
    input  logic [isb_pkg::PIX_W-1:0]   p10,
    input  logic [isb_pkg::PIX_W-1:0]   p01,
    input  logic [isb_pkg::PIX_W-1:0]   p11,
    input  logic [FRAC_BITS-1:0]        frac_x,
    input  logic [FRAC_BITS-1:0]        frac_y,
    input  logic                        sat,
    output logic [isb_pkg::PIX_W-1:0]   pixel_out,
    output logic                        clamped
);
    import isb_pkg::*;

    localparam int TW = PIX_W + FRAC_BITS;

    // Row blend: a*one + f*(b - a), exact
    logic signed [FRAC_BITS:0]    fx_s;
    logic signed [PIX_W:0]        d_top;
    logic signed [PIX_W:0]        d_bot;
    logic signed [TW+1:0]         m_top;
    logic signed [TW+1:0]         m_bot;
    logic signed [TW+1:0]         top_full;
    logic signed [TW+1:0]         bot_full;

    always_comb
    begin
        fx_s     = {1'b0, frac_x};
        d_top    = $signed({1'b0, p10}) - $signed({1'b0, p00});
        d_bot    = $signed({1'b0, p11}) - $signed({1'b0, p01});
        m_top    = fx_s * d_top;
        m_bot    = fx_s * d_bot;
        top_full = $signed({2'b00, p00, {FRAC_BITS{1'b0}}}) + m_top;
        bot_full = $signed({2'b00, p01, {FRAC_BITS{1'b0}}}) + m_bot;
    end

    // Stage 4
    logic [TW-1:0]        top4_reg;
    logic [TW-1:0]        bot4_reg;
    logic [FRAC_BITS-1:0] fy4_reg;
    logic                 sat4_reg;

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            top4_reg <= top_full[TW-1:0];
            bot4_reg <= bot_full[TW-1:0];
            fy4_reg  <= frac_y;
            sat4_reg <= sat;
        end
    end

    // Column blend, then drop both fractions
    logic signed [FRAC_BITS:0]      fy_s;
    logic signed [TW:0]             d_col;
    logic signed [TW+FRAC_BITS+1:0] m_col;
    logic signed [TW+FRAC_BITS+1:0] sum_full;
    logic [PIX_W-1:0]               pix_next;

    always_comb
    begin
        fy_s     = {1'b0, fy4_reg};
        d_col    = $signed({1'b0, bot4_reg}) - $signed({1'b0, top4_reg});
        m_col    = fy_s * d_col;
        sum_full = $signed({2'b00, top4_reg, {FRAC_BITS{1'b0}}}) + m_col;
        pix_next = sum_full[2*FRAC_BITS+PIX_W-1:2*FRAC_BITS];
    end

    // Stage 5: output register
    logic [PIX_W-1:0] pix5_reg;
    logic             sat5_reg;

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            pix5_reg <= pix_next;
            sat5_reg <= sat4_reg;
        end
    end

    assign pixel_out = pix5_reg;
    assign clamped   = sat5_reg;

endmodule

// ----- hdl/isb_checker.sv -----
// Port-level checks for the bilinear scaler, bound onto the top level.
// Depends on isb_pkg and image_scale_bilinear_unit.
module isb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             opcode,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [isb_pkg::PIX_W-1:0]        pixel_out,
    input logic                             clamped
);
    import isb_pkg::*;

    // Samples accepted but not yet delivered
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    logic       samp_beat;
    logic       out_beat;

    assign samp_beat = in_valid && in_ready && (opcode == OP_SAMPLE);
    assign out_beat  = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg + 4'(samp_beat) - 4'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // reset empties the result register
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid set after reset");

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(clamped))
        else $error("result beat changed while stalled");

    // with the result side free the input is never back-pressured
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled with free output");

    // every result belongs to an accepted sample
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cnt_reg != '0))
        else $error("result without a pending sample");

    // no more samples in flight than stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(PIPE_STAGES))
        else $error("more samples in flight than pipeline stages");

endmodule

bind image_scale_bilinear_unit isb_checker u_isb_checker (.*);
